// ----- design/nsu128_pkg.sv -----
package nsu128_pkg;

    // base_mode register codes
    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_DEC  = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;

    // ASCII codes the parser looks at
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;

    localparam int unsigned VAL_W = 128;

    // position relative to the first non-blank character
    typedef enum logic [2:0] {
        POS_START = 3'b001,
        POS_FIRST = 3'b010,
        POS_PAST  = 3'b100
    } t_pos;

    // per-string parse state
    typedef struct packed {
        logic [VAL_W-1:0] acc;
        logic             hex_active;
        t_pos             pos;
        logic             first_was_zero;
        logic             stopped;
        logic             overflowed;
    } t_str_state;

    localparam t_str_state STATE_CLEAR = '{
        acc:            '0,
        hex_active:     1'b0,
        pos:            POS_START,
        first_was_zero: 1'b0,
        stopped:        1'b0,
        overflowed:     1'b0
    };

endpackage

// ----- design/nsu128_in_if.sv -----
interface nsu128_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ----- design/nsu128_out_if.sv -----
interface nsu128_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic        status;

    modport source (output valid, output value_low, output value_high, output status,
                    input ready);
    modport sink   (input valid, input value_low, input value_high, input status,
                    output ready);
endinterface

// ----- design/nsu128_accum.sv -----
// One character step of the parser: prefix tracking, digit decode and
// value * base + digit with carry detection out of bit 127.
module nsu128_accum (
    input  nsu128_pkg::t_str_state i_cur,
    input  logic [7:0]             i_char,
    input  logic [1:0]             i_mode,
    output nsu128_pkg::t_str_state o_nxt
);

    localparam int unsigned EXT_W = nsu128_pkg::VAL_W + 4;

    logic             blank;
    logic             strip;
    logic             use_hex;
    logic             is_dec;
    logic             is_lo_hex;
    logic             is_up_hex;
    logic             is_digit;
    logic [3:0]       digit;
    logic [EXT_W-1:0] scaled;
    logic [EXT_W-1:0] sum;
    logic             carry;

    // character classes
    assign blank     = i_char inside {nsu128_pkg::CH_SPACE,
                                      [nsu128_pkg::CH_TAB:nsu128_pkg::CH_CR]};
    assign is_dec    = i_char inside {[nsu128_pkg::CH_ZERO:nsu128_pkg::CH_NINE]};
    assign is_lo_hex = i_char inside {[nsu128_pkg::CH_LO_A:nsu128_pkg::CH_LO_F]};
    assign is_up_hex = i_char inside {[nsu128_pkg::CH_UP_A:nsu128_pkg::CH_UP_F]};

    // prefix only completes on the character right after a leading '0'
    assign strip = (i_mode == nsu128_pkg::MODE_AUTO) &&
                   (i_cur.pos == nsu128_pkg::POS_FIRST) && i_cur.first_was_zero &&
                   (i_char inside {nsu128_pkg::CH_LO_X, nsu128_pkg::CH_UP_X});

    assign use_hex = (i_mode == nsu128_pkg::MODE_HEX) ||
                     ((i_mode == nsu128_pkg::MODE_AUTO) && (i_cur.hex_active || strip));

    // digit decode
    always_comb begin
        is_digit = 1'b0;
        digit    = '0;
        if (is_dec) begin
            is_digit = 1'b1;
            digit    = 4'(i_char - nsu128_pkg::CH_ZERO);
        end else if (use_hex && is_lo_hex) begin
            is_digit = 1'b1;
            digit    = 4'(i_char - nsu128_pkg::CH_LO_A + 8'd10);
        end else if (use_hex && is_up_hex) begin
            is_digit = 1'b1;
            digit    = 4'(i_char - nsu128_pkg::CH_UP_A + 8'd10);
        end
    end

    // times 16 is a shift, times 10 is x8 + x2
    always_comb begin
        if (use_hex) begin
            scaled = {i_cur.acc, 4'b0000};
        end else begin
            scaled = {1'b0, i_cur.acc, 3'b000} + {3'b000, i_cur.acc, 1'b0};
        end
    end

    assign sum   = scaled + EXT_W'(digit);
    assign carry = |sum[EXT_W-1:nsu128_pkg::VAL_W];

    // state update
    always_comb begin
        o_nxt = i_cur;
        if (!i_cur.stopped) begin
            if (i_mode == nsu128_pkg::MODE_AUTO) begin
                case (i_cur.pos)
                    nsu128_pkg::POS_START: begin
                        if (!blank) begin
                            o_nxt.pos            = nsu128_pkg::POS_FIRST;
                            o_nxt.first_was_zero = (i_char == nsu128_pkg::CH_ZERO);
                        end
                    end
                    nsu128_pkg::POS_FIRST: begin
                        o_nxt.pos = nsu128_pkg::POS_PAST;
                        if (strip) begin
                            o_nxt.hex_active = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (!strip && !blank) begin
                if (!is_digit) begin
                    o_nxt.stopped = 1'b1;
                end else if (carry) begin
                    o_nxt.overflowed = 1'b1;
                    o_nxt.stopped    = 1'b1;
                end else begin
                    o_nxt.acc = sum[nsu128_pkg::VAL_W-1:0];
                end
            end
        end
    end

endmodule

// ----- design/numeric_string_to_uint128_top.sv -----
// Streaming numeric-string parser to a 128-bit unsigned value. Characters
// arrive one per transfer on i_in, the last one flagged by last_char; one
// result per string leaves on o_out. A character is taken in every cycle
// unless a string's held last character waits on a full result register.
// It lands in an input register, then one step of value * base + digit
// (shift-and-add over 132 bits) updates the parse state, and a string's
// result passes from the input register to the result register, which
// lets the next string stream in while a result waits to be taken.
// base_mode (i_cfg_wdata) selects auto "0x" detection, fixed decimal or
// fixed hex; the user must write it only while no string is in flight,
// the block does not enforce this. On overflow the value reads zero and status is 1.
module numeric_string_to_uint128_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_wdata,
    nsu128_in_if.sink           i_in,
    nsu128_out_if.source        o_out
);

    logic [1:0]             r_mode;
    logic                   r_in_valid;
    logic [7:0]             r_char;
    logic                   r_last;
    nsu128_pkg::t_str_state r_state;
    nsu128_pkg::t_str_state n_state;
    logic                   r_out_valid;
    logic [63:0]            r_val_lo;
    logic [63:0]            r_val_hi;
    logic                   r_status;
    logic                   proc;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= nsu128_pkg::MODE_AUTO;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // the held character moves on unless it ends a string and the result slot is stuck
    assign proc       = r_in_valid && (!r_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_char <= i_in.character;
            r_last <= i_in.last_char;
        end
    end

    nsu128_accum u_accum (
        .i_cur  (r_state),
        .i_char (r_char),
        .i_mode (r_mode),
        .o_nxt  (n_state)
    );

    // parse state, cleared after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsu128_pkg::STATE_CLEAR;
        end else if (proc) begin
            r_state <= r_last ? nsu128_pkg::STATE_CLEAR : n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_last) begin
            r_status <= n_state.overflowed;
            r_val_lo <= n_state.overflowed ? '0 : n_state.acc[63:0];
            r_val_hi <= n_state.overflowed ? '0 : n_state.acc[127:64];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.value_low  = r_val_lo;
    assign o_out.value_high = r_val_hi;
    assign o_out.status     = r_status;

    // an overflowed result carries a zero value
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status |-> r_val_lo == '0 && r_val_hi == '0)
        else $error("overflow result with nonzero value");

    // the final character leaves a clean state for the next string
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_last |=> r_state.acc == '0 && r_state.pos == nsu128_pkg::POS_START &&
                           !r_state.stopped && !r_state.overflowed)
        else $error("parse state not cleared after final character");

    // overflow always ends accumulation
    a_ovf_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.overflowed |-> r_state.stopped)
        else $error("overflow without stop");

    // a stripped prefix implies the prefix window is closed
    a_hex_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hex_active |-> r_state.pos == nsu128_pkg::POS_PAST)
        else $error("hex active inside prefix window");

    // a held character that cannot move is kept, not dropped
    a_hold_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc |=> r_in_valid && $stable(r_char) && $stable(r_last))
        else $error("held character lost");

endmodule
